// ===== rtl/core/stts_pkg.sv =====
// shared types, codes and character classes of the smalltalk token scanner
package stts_pkg;

   localparam int LINE_BITS_DEFAULT   = 20;
   localparam int COLUMN_BITS_DEFAULT = 12;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // widths of the result fields
   localparam int LINE_W = 20;
   localparam int COL_W  = 12;

   // results one request can cause, and the width of their count
   localparam int GROUP_ITEMS = 3;
   localparam int GROUP_CNT_W = $clog2(GROUP_ITEMS + 1);

   // request codes
   localparam logic [1:0] REQ_CHAR = 2'd0;
   localparam logic [1:0] REQ_EOL  = 2'd1;
   localparam logic [1:0] REQ_EOI  = 2'd2;

   // token classes
   localparam logic [5:0] KIND_UNKNOWN   = 6'd0;
   localparam logic [5:0] KIND_IDENT     = 6'd1;
   localparam logic [5:0] KIND_KEYWORD   = 6'd2;
   localparam logic [5:0] KIND_KWSEQ     = 6'd3;
   localparam logic [5:0] KIND_INTEGER   = 6'd4;
   localparam logic [5:0] KIND_DECIMAL   = 6'd5;
   localparam logic [5:0] KIND_STRING    = 6'd6;
   localparam logic [5:0] KIND_PRIMITIVE = 6'd7;
   localparam logic [5:0] KIND_SEPARATOR = 6'd8;
   localparam logic [5:0] KIND_OPSEQ     = 6'd9;
   localparam logic [5:0] KIND_ASSIGN    = 6'd10;
   localparam logic [5:0] KIND_COLON     = 6'd11;
   localparam logic [5:0] KIND_LBRACKET  = 6'd12;
   localparam logic [5:0] KIND_RBRACKET  = 6'd13;
   localparam logic [5:0] KIND_LPAREN    = 6'd14;
   localparam logic [5:0] KIND_RPAREN    = 6'd15;
   localparam logic [5:0] KIND_HASH      = 6'd16;
   localparam logic [5:0] KIND_CARET     = 6'd17;
   localparam logic [5:0] KIND_PERIOD    = 6'd18;
   localparam logic [5:0] KIND_TILDE     = 6'd19;
   localparam logic [5:0] KIND_AMP       = 6'd20;
   localparam logic [5:0] KIND_BAR       = 6'd21;
   localparam logic [5:0] KIND_STAR      = 6'd22;
   localparam logic [5:0] KIND_SLASH     = 6'd23;
   localparam logic [5:0] KIND_BACKSLASH = 6'd24;
   localparam logic [5:0] KIND_PLUS      = 6'd25;
   localparam logic [5:0] KIND_EQUAL     = 6'd26;
   localparam logic [5:0] KIND_GREATER   = 6'd27;
   localparam logic [5:0] KIND_LESS      = 6'd28;
   localparam logic [5:0] KIND_COMMA     = 6'd29;
   localparam logic [5:0] KIND_AT        = 6'd30;
   localparam logic [5:0] KIND_PERCENT   = 6'd31;
   localparam logic [5:0] KIND_MINUS     = 6'd32;

   // characters with a role of their own
   localparam logic [7:0] CH_QUOTE     = 8'h27;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5c;
   localparam logic [7:0] CH_COLON     = 8'h3a;
   localparam logic [7:0] CH_EQUAL     = 8'h3d;
   localparam logic [7:0] CH_DASH      = 8'h2d;
   localparam logic [7:0] CH_DOT       = 8'h2e;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
   localparam logic [7:0] CH_LOWER_P   = 8'h70;
   localparam logic [7:0] CH_NEWLINE   = 8'h0a;

   typedef enum logic [3:0] {
      MODE_IDLE    = 4'd0,
      MODE_COMMENT = 4'd1,
      MODE_STRING  = 4'd2,
      MODE_ESCAPE  = 4'd3,
      MODE_IDENT   = 4'd4,
      MODE_KWCOLON = 4'd5,
      MODE_KWSEQ   = 4'd6,
      MODE_NUMBER  = 4'd7,
      MODE_COLON   = 4'd8,
      MODE_OPS     = 4'd9,
      MODE_SEP     = 4'd10
   } mode_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] in_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]        text_byte;
      logic              byte_valid;
      logic [5:0]        token_kind;
      logic              token_end;
      logic [7:0]        lead_char;
      logic [LINE_W-1:0] line_number;
      logic [COL_W-1:0]  start_column;
      logic              bad_escape;
      logic              run_last;
   } rsp_payload_type;

   // all results of one request
   typedef struct packed {
      rsp_payload_type [GROUP_ITEMS-1:0] item;
      logic [GROUP_CNT_W-1:0]            count;
   } group_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
   endfunction

   function automatic logic [5:0] op_kind(input logic [7:0] c);
      logic [5:0] k;
      case (c)
         8'h7e:   k = KIND_TILDE;
         8'h26:   k = KIND_AMP;
         8'h7c:   k = KIND_BAR;
         8'h2a:   k = KIND_STAR;
         8'h2f:   k = KIND_SLASH;
         8'h5c:   k = KIND_BACKSLASH;
         8'h2b:   k = KIND_PLUS;
         8'h3d:   k = KIND_EQUAL;
         8'h3e:   k = KIND_GREATER;
         8'h3c:   k = KIND_LESS;
         8'h2c:   k = KIND_COMMA;
         8'h40:   k = KIND_AT;
         8'h25:   k = KIND_PERCENT;
         8'h2d:   k = KIND_MINUS;
         default: k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

   function automatic logic [5:0] punct_kind(input logic [7:0] c);
      logic [5:0] k;
      case (c)
         8'h5b:   k = KIND_LBRACKET;
         8'h5d:   k = KIND_RBRACKET;
         8'h28:   k = KIND_LPAREN;
         8'h29:   k = KIND_RPAREN;
         8'h23:   k = KIND_HASH;
         8'h5e:   k = KIND_CARET;
         8'h2e:   k = KIND_PERIOD;
         default: k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

   // letters of the word primitive
   function automatic logic [7:0] prim_char(input logic [3:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:    ch = 8'h70;
         4'd1:    ch = 8'h72;
         4'd2:    ch = 8'h69;
         4'd3:    ch = 8'h6d;
         4'd4:    ch = 8'h69;
         4'd5:    ch = 8'h74;
         4'd6:    ch = 8'h69;
         4'd7:    ch = 8'h76;
         4'd8:    ch = 8'h65;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ===== rtl/core/smalltalk_token_scanner_top.sv =====
// top level of the smalltalk token scanner
//
//   channel   direction   payload                       handshake
//   req_      in          char / line end / input end   req_valid, req_ready
//   rsp_      out         one token text byte           rsp_valid, rsp_ready
//
// one request is taken per cycle while the group queue has room; a request yields
// zero to three results, which leave one per cycle from the back while rsp_ready is high
// sustained pace: set by the requests, or by the results when requests
// cause more than one
// reset clears the scanner to idle, line 1, column 0, and empties the queue
// a stalled rsp_ side fills the queue, then req_ready drops
module smalltalk_token_scanner_top #(
   parameter int LINE_BITS   = stts_pkg::LINE_BITS_DEFAULT,
   parameter int COLUMN_BITS = stts_pkg::COLUMN_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = stts_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  stts_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output stts_pkg::rsp_payload_type rsp_payload
);

   logic                q_push_valid, q_push_ready;
   stts_pkg::group_type q_push_group;
   logic                q_pop_valid, q_pop_ready;
   stts_pkg::group_type q_pop_group;

   stts_front #(
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_valid  (q_push_valid),
      .push_ready  (q_push_ready),
      .push_group  (q_push_group)
   );

   stts_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_group (q_push_group),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_group  (q_pop_group)
   );

   stts_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (q_pop_valid),
      .pop_ready   (q_pop_ready),
      .pop_group   (q_pop_group),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // every result carries a byte or closes a token
   a_item_content: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.byte_valid || rsp_payload.token_end))
      else $error("result with neither byte nor token end");

   // class only on the closing result
   a_kind_on_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.token_end) |-> (rsp_payload.token_kind == '0))
      else $error("token class on an inner byte");

   // a group is handed out without gaps
   a_group_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_payload.run_last) |=> rsp_valid)
      else $error("gap inside the results of one request");

endmodule

// ===== rtl/core/stts_front.sv =====
// scanner front: takes one request a cycle while the queue has room and builds the group of results it causes
module stts_front #(
   parameter int LINE_BITS   = stts_pkg::LINE_BITS_DEFAULT,
   parameter int COLUMN_BITS = stts_pkg::COLUMN_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  stts_pkg::req_payload_type req_payload,
   output logic                      push_valid,
   input  logic                      push_ready,
   output stts_pkg::group_type       push_group
);

   localparam int LineW = stts_pkg::LINE_W;
   localparam int ColW  = stts_pkg::COL_W;
   localparam int CntW  = stts_pkg::GROUP_CNT_W;

   stts_pkg::mode_type     mode_ff, mode_in;
   logic [7:0]             h0_ff, h0_in, h1_ff, h1_in;
   logic [1:0]             hc_ff, hc_in;
   logic                   dec_ff, dec_in;
   logic [LINE_BITS-1:0]   lc_ff, lc_in, tl_ff, tl_in;
   logic [COLUMN_BITS-1:0] cc_ff, cc_in, ts_ff, ts_in, dc_ff, dc_in;
   logic [3:0]             rl_ff, rl_in;
   logic                   ax_ff, ax_in;
   logic                   eb_ff, eb_in;

   stts_pkg::group_type    grp;
   logic                   req_fire;

   // scratch of the step logic
   logic [7:0]             c;
   logic                   prim;
   logic                   adv_en;
   logic [7:0]             adv_b;
   logic                   close_en;
   logic                   fin_en;
   logic [5:0]             fin_kind;
   logic [7:0]             fin_lead;
   logic                   dot_en;
   logic [5:0]             pk;
   logic [CntW-1:0]        n;

   function automatic stts_pkg::rsp_payload_type mk(
      input logic [7:0]             b,
      input logic                   v,
      input logic [5:0]             k,
      input logic                   e,
      input logic [7:0]             l,
      input logic                   bad,
      input logic [LINE_BITS-1:0]   ln,
      input logic [COLUMN_BITS-1:0] cl
   );
      stts_pkg::rsp_payload_type r;
      r.text_byte    = b;
      r.byte_valid   = v;
      r.token_kind   = k;
      r.token_end    = e;
      r.lead_char    = l;
      r.line_number  = LineW'(ln);
      r.start_column = ColW'(cl);
      r.bad_escape   = bad;
      r.run_last     = 1'b0;
      return r;
   endfunction

   // next state and result group of one request
   always_comb begin
      mode_in = mode_ff; h0_in = h0_ff; h1_in = h1_ff; hc_in = hc_ff;
      dec_in = dec_ff; lc_in = lc_ff; tl_in = tl_ff; cc_in = cc_ff;
      ts_in = ts_ff; dc_in = dc_ff; rl_in = rl_ff; ax_in = ax_ff; eb_in = eb_ff;
      grp = '0;
      n = '0;
      c = req_payload.in_byte;
      prim = ax_ff && (rl_ff == 4'd9);
      adv_en = 1'b0; adv_b = c; close_en = 1'b0;
      fin_en = 1'b0; fin_kind = stts_pkg::KIND_UNKNOWN; fin_lead = 8'h00;
      dot_en = 1'b0;
      pk = stts_pkg::punct_kind(c);

      // decide what the request does in the current mode
      unique case (req_payload.req_type)
         stts_pkg::REQ_CHAR: begin
            unique case (mode_ff)
               stts_pkg::MODE_COMMENT: begin
                  if (c == stts_pkg::CH_DQUOTE) mode_in = stts_pkg::MODE_IDLE;
               end
               stts_pkg::MODE_STRING: begin
                  if (c == stts_pkg::CH_QUOTE) begin
                     fin_en = 1'b1; fin_kind = stts_pkg::KIND_STRING;
                  end else if (c == stts_pkg::CH_BACKSLASH) begin
                     mode_in = stts_pkg::MODE_ESCAPE;
                  end else begin
                     adv_en = 1'b1;
                  end
               end
               stts_pkg::MODE_ESCAPE: begin
                  mode_in = stts_pkg::MODE_STRING;
                  adv_en = 1'b1;
                  case (c)
                     8'h74:   adv_b = 8'd9;
                     8'h62:   adv_b = 8'd8;
                     8'h6e:   adv_b = 8'd10;
                     8'h72:   adv_b = 8'd13;
                     8'h66:   adv_b = 8'd12;
                     8'h30:   adv_b = 8'd0;
                     8'h27:   adv_b = c;
                     8'h5c:   adv_b = c;
                     default: begin
                        adv_en = 1'b0;
                        eb_in = 1'b1;
                     end
                  endcase
               end
               stts_pkg::MODE_IDENT: begin
                  if (stts_pkg::is_alpha(c) || stts_pkg::is_digit(c) ||
                      (c == stts_pkg::CH_UNDERSCORE && !prim)) begin
                     if (ax_ff && !(rl_ff < 4'd9 && c == stts_pkg::prim_char(rl_ff)))
                        ax_in = 1'b0;
                     if (rl_ff != 4'd15) rl_in = rl_ff + 4'd1;
                     adv_en = 1'b1;
                  end else if (c == stts_pkg::CH_COLON && !prim) begin
                     adv_en = 1'b1;
                     mode_in = stts_pkg::MODE_KWCOLON;
                  end else begin
                     close_en = 1'b1;
                  end
               end
               stts_pkg::MODE_KWCOLON: begin
                  if (stts_pkg::is_alpha(c)) begin
                     adv_en = 1'b1;
                     mode_in = stts_pkg::MODE_KWSEQ;
                  end else begin
                     close_en = 1'b1;
                  end
               end
               stts_pkg::MODE_KWSEQ: begin
                  if (stts_pkg::is_alpha(c) || c == stts_pkg::CH_COLON) adv_en = 1'b1;
                  else close_en = 1'b1;
               end
               stts_pkg::MODE_NUMBER: begin
                  if (hc_ff == 2'd2) begin
                     // point held back until a digit confirms the decimal
                     if (stts_pkg::is_digit(c)) begin
                        adv_en = 1'b1;
                        dec_in = 1'b1;
                     end else begin
                        close_en = 1'b1;
                     end
                  end else if (stts_pkg::is_digit(c)) begin
                     adv_en = 1'b1;
                  end else if (c == stts_pkg::CH_DOT && !dec_ff && hc_ff == 2'd1) begin
                     h1_in = c;
                     hc_in = 2'd2;
                     dc_in = cc_ff;
                  end else begin
                     close_en = 1'b1;
                  end
               end
               stts_pkg::MODE_COLON: begin
                  if (c == stts_pkg::CH_EQUAL) begin
                     adv_en = 1'b1;
                     fin_en = 1'b1; fin_kind = stts_pkg::KIND_ASSIGN;
                  end else begin
                     close_en = 1'b1;
                  end
               end
               stts_pkg::MODE_OPS: begin
                  if (ax_ff && c == stts_pkg::CH_DASH) begin
                     adv_en = 1'b1;
                     rl_in = rl_ff + 4'd1;
                     if (rl_ff >= 4'd3) mode_in = stts_pkg::MODE_SEP;
                  end else if (stts_pkg::op_kind(c) != stts_pkg::KIND_UNKNOWN) begin
                     adv_en = 1'b1;
                     if (rl_ff != 4'd15) rl_in = rl_ff + 4'd1;
                     ax_in = 1'b0;
                  end else begin
                     close_en = 1'b1;
                  end
               end
               stts_pkg::MODE_SEP: begin
                  if (c == stts_pkg::CH_DASH) adv_en = 1'b1;
                  else close_en = 1'b1;
               end
               default: close_en = 1'b1;
            endcase
         end
         stts_pkg::REQ_EOL: begin
            if (mode_ff == stts_pkg::MODE_STRING || mode_ff == stts_pkg::MODE_ESCAPE) begin
               if (mode_ff == stts_pkg::MODE_ESCAPE) eb_in = 1'b1;
               mode_in = stts_pkg::MODE_STRING;
               adv_en = 1'b1;
               adv_b = stts_pkg::CH_NEWLINE;
            end else if (mode_ff != stts_pkg::MODE_COMMENT) begin
               close_en = 1'b1;
            end
         end
         stts_pkg::REQ_EOI: begin
            if (mode_ff != stts_pkg::MODE_COMMENT) close_en = 1'b1;
         end
         default: ;
      endcase

      // release held bytes and hold the new one
      if (adv_en) begin
         if (hc_in != 2'd0) begin
            grp.item[n] = mk(h0_in, 1'b1, stts_pkg::KIND_UNKNOWN, 1'b0, 8'h00, 1'b0,
                             tl_in, ts_in);
            n = n + 1'b1;
         end
         if (hc_in == 2'd2) begin
            grp.item[n] = mk(h1_in, 1'b1, stts_pkg::KIND_UNKNOWN, 1'b0, 8'h00, 1'b0,
                             tl_in, ts_in);
            n = n + 1'b1;
         end
         h0_in = adv_b;
         hc_in = 2'd1;
      end

      // end the pending token
      if (close_en) begin
         fin_en = 1'b1;
         unique case (mode_ff)
            stts_pkg::MODE_STRING, stts_pkg::MODE_ESCAPE: begin
               if (mode_ff == stts_pkg::MODE_ESCAPE) eb_in = 1'b1;
               fin_kind = stts_pkg::KIND_STRING;
            end
            stts_pkg::MODE_IDENT:
               fin_kind = prim ? stts_pkg::KIND_PRIMITIVE : stts_pkg::KIND_IDENT;
            stts_pkg::MODE_KWCOLON: fin_kind = stts_pkg::KIND_KEYWORD;
            stts_pkg::MODE_KWSEQ:   fin_kind = stts_pkg::KIND_KWSEQ;
            stts_pkg::MODE_NUMBER: begin
               fin_kind = dec_ff ? stts_pkg::KIND_DECIMAL : stts_pkg::KIND_INTEGER;
               // a point with no digit after it becomes its own token
               if (hc_in == 2'd2) begin
                  hc_in = 2'd1;
                  dot_en = 1'b1;
               end
            end
            stts_pkg::MODE_COLON: begin
               fin_kind = stts_pkg::KIND_COLON;
               fin_lead = stts_pkg::CH_COLON;
            end
            stts_pkg::MODE_OPS: begin
               if (rl_ff == 4'd1 && hc_in == 2'd1) begin
                  fin_kind = stts_pkg::op_kind(h0_in);
                  fin_lead = h0_in;
               end else begin
                  fin_kind = stts_pkg::KIND_OPSEQ;
               end
            end
            stts_pkg::MODE_SEP: fin_kind = stts_pkg::KIND_SEPARATOR;
            default: begin
               fin_en = 1'b0;
               hc_in = 2'd0;
               mode_in = stts_pkg::MODE_IDLE;
            end
         endcase
      end

      if (fin_en) begin
         if (hc_in == 2'd0) begin
            grp.item[n] = mk(8'h00, 1'b0, fin_kind, 1'b1, fin_lead, eb_in, tl_in, ts_in);
            n = n + 1'b1;
         end else if (hc_in == 2'd1) begin
            grp.item[n] = mk(h0_in, 1'b1, fin_kind, 1'b1, fin_lead, eb_in, tl_in, ts_in);
            n = n + 1'b1;
         end else begin
            grp.item[n] = mk(h0_in, 1'b1, stts_pkg::KIND_UNKNOWN, 1'b0, 8'h00, 1'b0,
                             tl_in, ts_in);
            n = n + 1'b1;
            grp.item[n] = mk(h1_in, 1'b1, fin_kind, 1'b1, fin_lead, eb_in, tl_in, ts_in);
            n = n + 1'b1;
         end
         hc_in = 2'd0;
         eb_in = 1'b0;
         mode_in = stts_pkg::MODE_IDLE;
      end

      if (dot_en) begin
         ts_in = dc_ff;
         grp.item[n] = mk(stts_pkg::CH_DOT, 1'b1, stts_pkg::KIND_PERIOD, 1'b1,
                          stts_pkg::CH_DOT, 1'b0, tl_in, ts_in);
         n = n + 1'b1;
      end

      // the character that ended a token starts the next one
      if (close_en && req_payload.req_type == stts_pkg::REQ_CHAR) begin
         mode_in = stts_pkg::MODE_IDLE;
         hc_in = 2'd0;
         if (stts_pkg::is_space(c)) begin
            mode_in = stts_pkg::MODE_IDLE;
         end else if (c == stts_pkg::CH_DQUOTE) begin
            mode_in = stts_pkg::MODE_COMMENT;
         end else begin
            ts_in = cc_ff;
            tl_in = lc_ff;
            eb_in = 1'b0;
            if (c == stts_pkg::CH_QUOTE) begin
               mode_in = stts_pkg::MODE_STRING;
            end else if (pk != stts_pkg::KIND_UNKNOWN) begin
               grp.item[n] = mk(c, 1'b1, pk, 1'b1, c, 1'b0, tl_in, ts_in);
               n = n + 1'b1;
            end else if (c == stts_pkg::CH_COLON) begin
               h0_in = c; hc_in = 2'd1;
               mode_in = stts_pkg::MODE_COLON;
            end else if (stts_pkg::op_kind(c) != stts_pkg::KIND_UNKNOWN) begin
               h0_in = c; hc_in = 2'd1;
               mode_in = stts_pkg::MODE_OPS;
               rl_in = 4'd1;
               ax_in = (c == stts_pkg::CH_DASH);
            end else if (stts_pkg::is_alpha(c)) begin
               h0_in = c; hc_in = 2'd1;
               mode_in = stts_pkg::MODE_IDENT;
               rl_in = 4'd1;
               ax_in = (c == stts_pkg::CH_LOWER_P);
            end else if (stts_pkg::is_digit(c)) begin
               h0_in = c; hc_in = 2'd1;
               mode_in = stts_pkg::MODE_NUMBER;
               dec_in = 1'b0;
            end else begin
               grp.item[n] = mk(c, 1'b1, stts_pkg::KIND_UNKNOWN, 1'b1, c, 1'b0,
                                tl_in, ts_in);
               n = n + 1'b1;
            end
         end
      end

      // position counters
      unique case (req_payload.req_type)
         stts_pkg::REQ_CHAR: begin
            if (cc_ff != '1) cc_in = cc_ff + 1'b1;
         end
         stts_pkg::REQ_EOL: begin
            if (lc_ff != '1) lc_in = lc_ff + 1'b1;
            cc_in = '0;
         end
         stts_pkg::REQ_EOI: begin
            mode_in = stts_pkg::MODE_IDLE;
            hc_in = 2'd0;
            lc_in = LINE_BITS'(1);
            cc_in = '0;
         end
         default: ;
      endcase

      if (n != '0) grp.item[n - 1'b1].run_last = 1'b1;
      grp.count = n;
   end

   // handshake toward the queue
   always_comb begin
      req_ready  = push_ready;
      req_fire   = req_valid && push_ready;
      push_valid = req_fire && (grp.count != '0);
      push_group = grp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= stts_pkg::MODE_IDLE;
         hc_ff   <= 2'd0;
         dec_ff  <= 1'b0;
         lc_ff   <= LINE_BITS'(1);
         cc_ff   <= '0;
         tl_ff   <= '0;
         ts_ff   <= '0;
         dc_ff   <= '0;
         rl_ff   <= 4'd0;
         ax_ff   <= 1'b0;
         eb_ff   <= 1'b0;
      end else if (req_fire) begin
         mode_ff <= mode_in;
         hc_ff   <= hc_in;
         dec_ff  <= dec_in;
         lc_ff   <= lc_in;
         cc_ff   <= cc_in;
         tl_ff   <= tl_in;
         ts_ff   <= ts_in;
         dc_ff   <= dc_in;
         rl_ff   <= rl_in;
         ax_ff   <= ax_in;
         eb_ff   <= eb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         h0_ff <= h0_in;
         h1_ff <= h1_in;
      end
   end

endmodule

// ===== rtl/core/stts_queue.sv =====
// short queue of result groups between scanner front and output back
module stts_queue #(
   parameter int QUEUE_DEPTH = stts_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  stts_pkg::group_type push_group,
   output logic                pop_valid,
   input  logic                pop_ready,
   output stts_pkg::group_type pop_group
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   stts_pkg::group_type slot_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic                push, pop;

   always_comb begin
      push_ready = (cnt_ff != CntW'(QUEUE_DEPTH));
      pop_valid  = (cnt_ff != '0);
      pop_group  = slot_ff[rd_ff];
      push = push_valid && push_ready;
      pop  = pop_valid && pop_ready;
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) wr_in = (wr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_group;
   end

endmodule

// ===== rtl/core/stts_back.sv =====
// output back: hands out the results of one group, one per cycle while rsp_ready is high
module stts_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  stts_pkg::group_type           pop_group,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output stts_pkg::rsp_payload_type     rsp_payload
);

   localparam int CntW = stts_pkg::GROUP_CNT_W;

   stts_pkg::group_type cur_ff;
   logic                cur_valid_ff;
   logic [CntW-1:0]     idx_ff;
   logic                last;

   always_comb begin
      last        = (idx_ff == cur_ff.count - 1'b1);
      rsp_valid   = cur_valid_ff;
      rsp_payload = cur_ff.item[idx_ff];
      // next group loads while the last result of this one leaves
      pop_ready   = !cur_valid_ff || (rsp_ready && last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else if (pop_valid && pop_ready) begin
         cur_valid_ff <= 1'b1;
         idx_ff       <= '0;
      end else if (cur_valid_ff && rsp_ready) begin
         if (last) cur_valid_ff <= 1'b0;
         else idx_ff <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready) cur_ff <= pop_group;
   end

endmodule

// ===== verif/smalltalk_token_scanner_top_test.sv =====
// testbench of the smalltalk token scanner: directed table, then random source text
module smalltalk_token_scanner_top_test;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int TOTAL_ITEMS = 360;
   localparam int QUIET_TAIL = 60;
   localparam logic [1:0] REQ_NONE = 2'd3;

   typedef struct {
      stts_pkg::req_payload_type p;
      bit                        typed;
      stts_pkg::rsp_payload_type want;
   } stim_entry_type;

   typedef struct {
      logic [1:0] t;
      logic [7:0] b;
      bit         typed;
      logic [5:0] kind;
      logic [11:0] col;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   stts_pkg::req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   stts_pkg::rsp_payload_type rsp_payload;

   smalltalk_token_scanner_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   always #1 clock = ~clock;

   stim_entry_type stim_q[$];
   stim_entry_type cur_req;
   stts_pkg::rsp_payload_type token_q[$];
   int errors = 0;
   int cycles = 0;
   bit quiet = 1'b0;
   bit long_hold_req = 1'b0;

   // scanner state for prediction
   stts_pkg::mode_type scan;
   logic [7:0]  held [9];
   int unsigned held_n;
   bit          dec_seen;
   logic [19:0] line_cnt;
   logic [11:0] col_cnt;
   logic [11:0] tok_col;
   logic [19:0] tok_line;
   logic [11:0] dot_col;
   int unsigned run_n;
   bit          prefix_ok;
   bit          esc_bad;
   stts_pkg::rsp_payload_type step_q[$];

   const string PRIM_WORD = "primitive";
   const string OP_CHARS = "~&|*/\\+=><,@%-";
   const string PUNCT_CHARS = "[]()#^.";

   function automatic bit letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit numeral(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit blank(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic [5:0] op_class(logic [7:0] c);
      case (c)
         "~": return stts_pkg::KIND_TILDE;
         "&": return stts_pkg::KIND_AMP;
         "|": return stts_pkg::KIND_BAR;
         "*": return stts_pkg::KIND_STAR;
         "/": return stts_pkg::KIND_SLASH;
         "\\": return stts_pkg::KIND_BACKSLASH;
         "+": return stts_pkg::KIND_PLUS;
         "=": return stts_pkg::KIND_EQUAL;
         ">": return stts_pkg::KIND_GREATER;
         "<": return stts_pkg::KIND_LESS;
         ",": return stts_pkg::KIND_COMMA;
         "@": return stts_pkg::KIND_AT;
         "%": return stts_pkg::KIND_PERCENT;
         "-": return stts_pkg::KIND_MINUS;
         default: return stts_pkg::KIND_UNKNOWN;
      endcase
   endfunction

   function automatic logic [5:0] punct_class(logic [7:0] c);
      case (c)
         "[": return stts_pkg::KIND_LBRACKET;
         "]": return stts_pkg::KIND_RBRACKET;
         "(": return stts_pkg::KIND_LPAREN;
         ")": return stts_pkg::KIND_RPAREN;
         "#": return stts_pkg::KIND_HASH;
         "^": return stts_pkg::KIND_CARET;
         ".": return stts_pkg::KIND_PERIOD;
         default: return stts_pkg::KIND_UNKNOWN;
      endcase
   endfunction

   function automatic void emit(logic [7:0] b, bit v, logic [5:0] kind, bit e,
                                logic [7:0] lead, bit bad);
      stts_pkg::rsp_payload_type r;
      if (step_q.size() >= 16) return;
      r.text_byte = b;
      r.byte_valid = v;
      r.token_kind = kind;
      r.token_end = e;
      r.lead_char = lead;
      r.line_number = tok_line;
      r.start_column = tok_col;
      r.bad_escape = bad;
      r.run_last = 1'b0;
      step_q.push_back(r);
   endfunction

   // release held bytes as inner text and keep b
   function automatic void shift_in(logic [7:0] b);
      for (int i = 0; i < held_n && i < 9; i++)
         emit(held[i], 1, stts_pkg::KIND_UNKNOWN, 0, 0, 0);
      held[0] = b;
      held_n = 1;
   endfunction

   function automatic void close_out(logic [5:0] kind, logic [7:0] lead);
      if (held_n == 0 || held_n > 9) begin
         emit(0, 0, kind, 1, lead, esc_bad);
      end else begin
         for (int i = 0; i + 1 < held_n; i++)
            emit(held[i], 1, stts_pkg::KIND_UNKNOWN, 0, 0, 0);
         emit(held[held_n-1], 1, kind, 1, lead, esc_bad);
      end
      held_n = 0;
      esc_bad = 0;
      scan = stts_pkg::MODE_IDLE;
   endfunction

   function automatic void end_token();
      logic [5:0] k;
      case (scan)
         stts_pkg::MODE_STRING, stts_pkg::MODE_ESCAPE: begin
            if (scan == stts_pkg::MODE_ESCAPE) esc_bad = 1;
            close_out(stts_pkg::KIND_STRING, 0);
         end
         stts_pkg::MODE_IDENT:
            close_out((prefix_ok && run_n == 9) ? stts_pkg::KIND_PRIMITIVE
                                                : stts_pkg::KIND_IDENT, 0);
         stts_pkg::MODE_KWCOLON: close_out(stts_pkg::KIND_KEYWORD, 0);
         stts_pkg::MODE_KWSEQ: close_out(stts_pkg::KIND_KWSEQ, 0);
         stts_pkg::MODE_NUMBER: begin
            k = dec_seen ? stts_pkg::KIND_DECIMAL : stts_pkg::KIND_INTEGER;
            if (held_n == 2) begin
               // trailing point with no digit after it becomes its own token
               held_n = 1;
               close_out(k, 0);
               tok_col = dot_col;
               emit(stts_pkg::CH_DOT, 1, stts_pkg::KIND_PERIOD, 1, stts_pkg::CH_DOT, 0);
            end else begin
               close_out(k, 0);
            end
         end
         stts_pkg::MODE_COLON: close_out(stts_pkg::KIND_COLON, stts_pkg::CH_COLON);
         stts_pkg::MODE_OPS: begin
            if (run_n == 1 && held_n == 1) close_out(op_class(held[0]), held[0]);
            else close_out(stts_pkg::KIND_OPSEQ, 0);
         end
         stts_pkg::MODE_SEP: close_out(stts_pkg::KIND_SEPARATOR, 0);
         default: begin
            held_n = 0;
            scan = stts_pkg::MODE_IDLE;
         end
      endcase
   endfunction

   function automatic void begin_token(logic [7:0] c, logic [11:0] col);
      logic [5:0] k;
      scan = stts_pkg::MODE_IDLE;
      held_n = 0;
      if (blank(c)) return;
      if (c == stts_pkg::CH_DQUOTE) begin
         scan = stts_pkg::MODE_COMMENT;
         return;
      end
      tok_col = col;
      tok_line = line_cnt;
      esc_bad = 0;
      if (c == stts_pkg::CH_QUOTE) begin
         scan = stts_pkg::MODE_STRING;
         return;
      end
      k = punct_class(c);
      if (k != stts_pkg::KIND_UNKNOWN) begin
         emit(c, 1, k, 1, c, 0);
      end else if (c == stts_pkg::CH_COLON) begin
         shift_in(c);
         scan = stts_pkg::MODE_COLON;
      end else if (op_class(c) != stts_pkg::KIND_UNKNOWN) begin
         shift_in(c);
         scan = stts_pkg::MODE_OPS;
         run_n = 1;
         prefix_ok = (c == stts_pkg::CH_DASH);
      end else if (letter(c)) begin
         shift_in(c);
         scan = stts_pkg::MODE_IDENT;
         run_n = 1;
         prefix_ok = (c == stts_pkg::CH_LOWER_P);
      end else if (numeral(c)) begin
         shift_in(c);
         scan = stts_pkg::MODE_NUMBER;
         dec_seen = 0;
      end else begin
         emit(c, 1, stts_pkg::KIND_UNKNOWN, 1, c, 0);
      end
   endfunction

   function automatic void take_char(logic [7:0] c, logic [11:0] col);
      bit prim;
      case (scan)
         stts_pkg::MODE_COMMENT: begin
            if (c == stts_pkg::CH_DQUOTE) scan = stts_pkg::MODE_IDLE;
            return;
         end
         stts_pkg::MODE_STRING: begin
            if (c == stts_pkg::CH_QUOTE) close_out(stts_pkg::KIND_STRING, 0);
            else if (c == stts_pkg::CH_BACKSLASH) scan = stts_pkg::MODE_ESCAPE;
            else shift_in(c);
            return;
         end
         stts_pkg::MODE_ESCAPE: begin
            scan = stts_pkg::MODE_STRING;
            case (c)
               "t": shift_in(8'd9);
               "b": shift_in(8'd8);
               "n": shift_in(8'd10);
               "r": shift_in(8'd13);
               "f": shift_in(8'd12);
               "0": shift_in(8'd0);
               stts_pkg::CH_QUOTE: shift_in(stts_pkg::CH_QUOTE);
               stts_pkg::CH_BACKSLASH: shift_in(stts_pkg::CH_BACKSLASH);
               default: esc_bad = 1;
            endcase
            return;
         end
         stts_pkg::MODE_IDENT: begin
            prim = prefix_ok && run_n == 9;
            if (letter(c) || numeral(c) || (c == stts_pkg::CH_UNDERSCORE && !prim)) begin
               if (prefix_ok && !(run_n < 9 && c == PRIM_WORD[run_n])) prefix_ok = 0;
               if (run_n < 15) run_n++;
               shift_in(c);
               return;
            end
            if (c == stts_pkg::CH_COLON && !prim) begin
               shift_in(c);
               scan = stts_pkg::MODE_KWCOLON;
               return;
            end
         end
         stts_pkg::MODE_KWCOLON: begin
            if (letter(c)) begin
               shift_in(c);
               scan = stts_pkg::MODE_KWSEQ;
               return;
            end
         end
         stts_pkg::MODE_KWSEQ: begin
            if (letter(c) || c == stts_pkg::CH_COLON) begin
               shift_in(c);
               return;
            end
         end
         stts_pkg::MODE_NUMBER: begin
            if (held_n == 2) begin
               if (numeral(c)) begin
                  shift_in(c);
                  dec_seen = 1;
                  return;
               end
            end else if (numeral(c)) begin
               shift_in(c);
               return;
            end else if (c == stts_pkg::CH_DOT && !dec_seen && held_n == 1) begin
               held[1] = c;
               held_n = 2;
               dot_col = col;
               return;
            end
         end
         stts_pkg::MODE_COLON: begin
            if (c == stts_pkg::CH_EQUAL) begin
               shift_in(c);
               close_out(stts_pkg::KIND_ASSIGN, 0);
               return;
            end
         end
         stts_pkg::MODE_OPS: begin
            if (prefix_ok && c == stts_pkg::CH_DASH) begin
               shift_in(c);
               run_n++;
               if (run_n >= 4) scan = stts_pkg::MODE_SEP;
               return;
            end
            if (op_class(c) != stts_pkg::KIND_UNKNOWN) begin
               shift_in(c);
               if (run_n < 15) run_n++;
               prefix_ok = 0;
               return;
            end
         end
         stts_pkg::MODE_SEP: begin
            if (c == stts_pkg::CH_DASH) begin
               shift_in(c);
               return;
            end
         end
         default: ;
      endcase
      end_token();
      begin_token(c, col);
   endfunction

   function automatic void predict_tokens(stts_pkg::req_payload_type p);
      step_q.delete();
      case (p.req_type)
         stts_pkg::REQ_CHAR: begin
            take_char(p.in_byte, col_cnt);
            if (col_cnt != '1) col_cnt++;
         end
         stts_pkg::REQ_EOL: begin
            if (scan == stts_pkg::MODE_STRING || scan == stts_pkg::MODE_ESCAPE) begin
               if (scan == stts_pkg::MODE_ESCAPE) esc_bad = 1;
               scan = stts_pkg::MODE_STRING;
               shift_in(stts_pkg::CH_NEWLINE);
            end else if (scan != stts_pkg::MODE_COMMENT) begin
               end_token();
            end
            if (line_cnt != '1) line_cnt++;
            col_cnt = 0;
         end
         stts_pkg::REQ_EOI: begin
            if (scan != stts_pkg::MODE_COMMENT) end_token();
            scan = stts_pkg::MODE_IDLE;
            held_n = 0;
            line_cnt = 1;
            col_cnt = 0;
         end
         default: ;
      endcase
      if (step_q.size() > 0) step_q[step_q.size()-1].run_last = 1'b1;
   endfunction

   function automatic void report(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   // request accepted: predict its tokens
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         predict_tokens(cur_req.p);
         if (cur_req.typed) begin
            step_q.delete();
            step_q.push_back(cur_req.want);
         end
         foreach (step_q[i]) token_q.push_back(step_q[i]);
      end
   end

   always @(posedge clock) begin
      stts_pkg::rsp_payload_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (token_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, rsp_payload);
            errors++;
         end else begin
            w = token_q.pop_front();
            report("text_byte", w.text_byte, rsp_payload.text_byte);
            report("byte_valid", w.byte_valid, rsp_payload.byte_valid);
            report("token_kind", w.token_kind, rsp_payload.token_kind);
            report("token_end", w.token_end, rsp_payload.token_end);
            report("lead_char", w.lead_char, rsp_payload.lead_char);
            report("line_number", w.line_number, rsp_payload.line_number);
            report("start_column", w.start_column, rsp_payload.start_column);
            report("bad_escape", w.bad_escape, rsp_payload.bad_escape);
            report("run_last", w.run_last, rsp_payload.run_last);
         end
      end
   end

   // receiver: random stall bursts, one long hold-off on request
   int unsigned stall_left = 0;
   int unsigned hold_left = 0;
   bit hold_done = 1'b0;
   always @(posedge clock) begin
      if (long_hold_req && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= 120;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (quiet) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 11) == 0) begin
         stall_left <= $urandom_range(1, 18) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic void add(logic [1:0] t, logic [7:0] b);
      stim_entry_type e;
      e.p.req_type = t;
      e.p.in_byte = b;
      e.typed = 0;
      e.want = '0;
      stim_q.push_back(e);
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) add(stts_pkg::REQ_CHAR, s[i]);
   endfunction

   function automatic logic [7:0] pick(string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] any_digit();
      return 8'("0" + $urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] any_letter();
      logic [7:0] c;
      c = 8'("a" + $urandom_range(0, 25));
      return $urandom_range(0, 1) ? c : c - 8'h20;
   endfunction

   function automatic void add_word(int n);
      add(stts_pkg::REQ_CHAR, any_letter());
      for (int i = 1; i < n; i++) begin
         case ($urandom_range(0, 5))
            0: add(stts_pkg::REQ_CHAR, any_digit());
            1: add(stts_pkg::REQ_CHAR, stts_pkg::CH_UNDERSCORE);
            default: add(stts_pkg::REQ_CHAR, any_letter());
         endcase
      end
   endfunction

   // one random piece of source text, mostly well formed
   function automatic void add_fragment();
      case ($urandom_range(0, 21))
         0, 1, 2: add_word($urandom_range(1, 6));
         3: begin
            case ($urandom_range(0, 3))
               0: add_text("primitive");
               1: add_text("primitive_");
               2: add_text("primitiv");
               default: add_text("primitivex");
            endcase
         end
         4: begin
            add_word($urandom_range(1, 3));
            add(stts_pkg::REQ_CHAR, stts_pkg::CH_COLON);
            for (int i = $urandom_range(0, 2); i > 0; i--) begin
               add_word($urandom_range(1, 3));
               if ($urandom_range(0, 1)) add(stts_pkg::REQ_CHAR, stts_pkg::CH_COLON);
            end
         end
         5: begin
            for (int i = $urandom_range(1, 3); i > 0; i--)
               add(stts_pkg::REQ_CHAR, any_digit());
            if ($urandom_range(0, 2) != 0) begin
               add(stts_pkg::REQ_CHAR, stts_pkg::CH_DOT);
               for (int i = $urandom_range(0, 2); i > 0; i--)
                  add(stts_pkg::REQ_CHAR, any_digit());
               if ($urandom_range(0, 2) == 0) add_text(".5");
            end
         end
         6, 7: begin
            add(stts_pkg::REQ_CHAR, stts_pkg::CH_QUOTE);
            for (int i = $urandom_range(0, 5); i > 0; i--) begin
               case ($urandom_range(0, 7))
                  0: begin
                     add(stts_pkg::REQ_CHAR, stts_pkg::CH_BACKSLASH);
                     add(stts_pkg::REQ_CHAR, pick("tbnrf0'\\\\qx"));
                  end
                  1: add(stts_pkg::REQ_CHAR, stts_pkg::CH_BACKSLASH);
                  2: add(stts_pkg::REQ_EOL, any_byte());
                  3: add_text("''");
                  default: add(stts_pkg::REQ_CHAR, any_byte());
               endcase
            end
            if ($urandom_range(0, 5) != 0) add(stts_pkg::REQ_CHAR, stts_pkg::CH_QUOTE);
         end
         8: begin
            add(stts_pkg::REQ_CHAR, stts_pkg::CH_DQUOTE);
            for (int i = $urandom_range(0, 4); i > 0; i--) begin
               if ($urandom_range(0, 3) == 0) add(stts_pkg::REQ_EOL, any_byte());
               else add(stts_pkg::REQ_CHAR, any_byte());
            end
            add(stts_pkg::REQ_CHAR, stts_pkg::CH_DQUOTE);
         end
         9: for (int i = $urandom_range(1, 3); i > 0; i--)
               add(stts_pkg::REQ_CHAR, pick(OP_CHARS));
         10: for (int i = $urandom_range(1, 6); i > 0; i--)
                add(stts_pkg::REQ_CHAR, stts_pkg::CH_DASH);
         11: begin
            add(stts_pkg::REQ_CHAR, stts_pkg::CH_COLON);
            if ($urandom_range(0, 1)) add(stts_pkg::REQ_CHAR, stts_pkg::CH_EQUAL);
         end
         12: add(stts_pkg::REQ_CHAR, pick(PUNCT_CHARS));
         13: add(stts_pkg::REQ_CHAR, any_byte());
         14: add(stts_pkg::REQ_EOL, any_byte());
         15: begin
            if ($urandom_range(0, 3) == 0) add(stts_pkg::REQ_EOI, any_byte());
            else add(stts_pkg::REQ_CHAR, " ");
         end
         16: add(REQ_NONE, any_byte());
         default: add(stts_pkg::REQ_CHAR, pick(" \t "));
      endcase
   endfunction

   task automatic send(stim_entry_type e, bit may_idle);
      int unsigned gap;
      gap = (may_idle && $urandom_range(0, 9) == 0) ? $urandom_range(1, 18) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= e.p;
      cur_req <= e;
      do @(posedge clock); while (!req_ready);
   endtask

   table_row_type dir_rows [] = '{
      '{stts_pkg::REQ_CHAR, "(", 1, stts_pkg::KIND_LPAREN, 0},
      '{stts_pkg::REQ_CHAR, 8'h80, 1, stts_pkg::KIND_UNKNOWN, 1},
      '{stts_pkg::REQ_CHAR, 8'h00, 1, stts_pkg::KIND_UNKNOWN, 2},
      '{stts_pkg::REQ_CHAR, 8'hff, 1, stts_pkg::KIND_UNKNOWN, 3},
      '{stts_pkg::REQ_CHAR, "_", 1, stts_pkg::KIND_UNKNOWN, 4},
      '{stts_pkg::REQ_CHAR, "^", 1, stts_pkg::KIND_CARET, 5},
      '{stts_pkg::REQ_CHAR, "p", 0, 0, 0}, '{stts_pkg::REQ_CHAR, "r", 0, 0, 0},
      '{stts_pkg::REQ_CHAR, "i", 0, 0, 0}, '{stts_pkg::REQ_CHAR, "m", 0, 0, 0},
      '{stts_pkg::REQ_CHAR, "i", 0, 0, 0}, '{stts_pkg::REQ_CHAR, "t", 0, 0, 0},
      '{stts_pkg::REQ_CHAR, "i", 0, 0, 0}, '{stts_pkg::REQ_CHAR, "v", 0, 0, 0},
      '{stts_pkg::REQ_CHAR, "e", 0, 0, 0},
      '{stts_pkg::REQ_EOL, 8'hff, 0, 0, 0},
      '{stts_pkg::REQ_CHAR, "'", 0, 0, 0}, '{stts_pkg::REQ_CHAR, "\\", 0, 0, 0},
      '{stts_pkg::REQ_CHAR, "q", 0, 0, 0},
      '{stts_pkg::REQ_EOI, 8'h00, 0, 0, 0},
      '{stts_pkg::REQ_CHAR, "3", 0, 0, 0}, '{stts_pkg::REQ_CHAR, ".", 0, 0, 0},
      '{stts_pkg::REQ_EOL, 8'h00, 0, 0, 0},
      '{stts_pkg::REQ_CHAR, "\"", 0, 0, 0}, '{stts_pkg::REQ_EOI, 8'hff, 0, 0, 0},
      '{REQ_NONE, 8'h5a, 0, 0, 0}
   };

   initial begin
      int n_dir;
      scan = stts_pkg::MODE_IDLE;
      held_n = 0;
      dec_seen = 0;
      line_cnt = 1;
      col_cnt = 0;
      tok_col = 0;
      tok_line = 0;
      dot_col = 0;
      run_n = 0;
      prefix_ok = 0;
      esc_bad = 0;
      cur_req.p = '0;
      cur_req.typed = 0;
      cur_req.want = '0;

      foreach (dir_rows[i]) begin
         add(dir_rows[i].t, dir_rows[i].b);
         if (dir_rows[i].typed) begin
            stim_q[i].typed = 1;
            stim_q[i].want = '{text_byte: dir_rows[i].b, byte_valid: 1'b1,
                               token_kind: dir_rows[i].kind, token_end: 1'b1,
                               lead_char: dir_rows[i].b, line_number: 20'd1,
                               start_column: dir_rows[i].col, bad_escape: 1'b0,
                               run_last: 1'b1};
         end
      end
      n_dir = stim_q.size();
      while (stim_q.size() < TOTAL_ITEMS - 1) add_fragment();
      add(stts_pkg::REQ_EOI, 8'h00);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < n_dir; i++) send(stim_q[i], 1);
      // pause until the directed part has fully drained
      req_valid <= 1'b0;
      wait (token_q.size() == 0);
      @(posedge clock);
      long_hold_req = 1'b1;
      for (int i = n_dir; i < stim_q.size(); i++) begin
         if (i == stim_q.size() - QUIET_TAIL) quiet = 1'b1;
         send(stim_q[i], !quiet);
      end
      req_valid <= 1'b0;
      while (token_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
